@@ hw/rtl/tlpq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpq_pkg
// Shared types and codes for the three-level priority queue and its cells.
// ----------------------------------------------------------------------------
package tlpq_pkg;

    localparam int LEVEL_BITS    = 2;
    localparam int PAYLOAD_BITS  = 7;
    localparam int PORT_KEY_BITS = 16;
    localparam int OCC_BITS      = 5;
    localparam int STATUS_BITS   = 3;

    localparam logic [LEVEL_BITS-1:0] LEVEL_NONE = 2'd0;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_POP    = 2'd1,
        KIND_UPDATE = 2'd2,
        KIND_NOP    = 2'd3
    } t_kind;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK        = 3'd0,
        STATUS_FULL      = 3'd1,
        STATUS_EMPTY     = 3'd2,
        STATUS_NOT_FOUND = 3'd3,
        STATUS_BAD_LEVEL = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_POP    = 2'd2,
        CELL_REMOVE = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic [LEVEL_BITS-1:0]   level;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_slot;

    typedef struct packed {
        t_cell_op op;
        t_slot    entry;
    } t_cell_cmd;

    typedef enum logic {
        ST_IDLE     = 1'b0,
        ST_REINSERT = 1'b1
    } t_state;

endpackage

@@ hw/rtl/tlpq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpq_cell
// One queue slot: holds key, level and payload and moves them to or from
// its neighbors on insert, pop and remove commands.
// ----------------------------------------------------------------------------
module tlpq_cell #(
    parameter int KW = 16
) (
    input  logic               i_clk,
    input  tlpq_pkg::t_cell_cmd i_cmd,
    input  logic [KW-1:0]      i_cmd_key,
    input  logic               i_occupied,
    input  logic               i_left_stay,
    input  logic               i_left_hit,
    input  logic [KW-1:0]      i_left_key,
    input  tlpq_pkg::t_slot    i_left_slot,
    input  logic [KW-1:0]      i_right_key,
    input  tlpq_pkg::t_slot    i_right_slot,
    output logic               o_stay,
    output logic               o_hit,
    output logic [KW-1:0]      o_key,
    output tlpq_pkg::t_slot    o_slot,
    output logic [KW-1:0]      o_n_key,
    output tlpq_pkg::t_slot    o_n_slot
);

    logic [KW-1:0]   r_key;
    tlpq_pkg::t_slot r_slot;
    logic [KW-1:0]   n_key;
    tlpq_pkg::t_slot n_slot;
    logic            w_stay;
    logic            w_hit;

    // levels are kept in non-increasing order, so stay bits form a prefix
    assign w_stay = i_occupied && (r_slot.level >= i_cmd.entry.level);
    assign w_hit  = i_occupied && (r_key == i_cmd_key);

    always_comb begin
        n_key  = r_key;
        n_slot = r_slot;
        unique case (i_cmd.op)
            tlpq_pkg::CELL_HOLD: begin
                n_key  = r_key;
            end
            tlpq_pkg::CELL_INSERT: begin
                if (!i_left_stay) begin
                    n_key  = i_left_key;
                    n_slot = i_left_slot;
                end else if (!w_stay) begin
                    n_key  = i_cmd_key;
                    n_slot = i_cmd.entry;
                end
            end
            tlpq_pkg::CELL_POP: begin
                n_key  = i_right_key;
                n_slot = i_right_slot;
            end
            tlpq_pkg::CELL_REMOVE: begin
                // close the gap at and behind the first matching slot
                if (i_left_hit || w_hit) begin
                    n_key  = i_right_key;
                    n_slot = i_right_slot;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_slot <= n_slot;
    end

    assign o_stay   = w_stay;
    assign o_hit    = w_hit;
    assign o_key    = r_key;
    assign o_slot   = r_slot;
    assign o_n_key  = n_key;
    assign o_n_slot = n_slot;

endmodule

@@ hw/rtl/three_level_priority_queue_unit.sv @@
`timescale 1ns / 1ps
// add, pop, no-op and failed commands give their result from the output register in the cycle after the beat
// an update that finds its key runs a remove pass, then an insert pass, and gives its result after the insert pass
// an update that finds its key takes no new command during its insert pass on the shared cell row
// a new beat is taken while the previous result drains from the output register
// reset: synchronous active-low; empties the queue and the output register
// slot contents are not cleared, slots beyond the count are never reported
// ----------------------------------------------------------------------------
// three_level_priority_queue_unit
// Strict three-level priority queue built as a row of slot cells with add,
// pop, reprioritize and no-op commands.
// ----------------------------------------------------------------------------
module three_level_priority_queue_unit #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_entry_key,
    input  logic [1:0]  i_level,
    input  logic [6:0]  i_payload,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_removed_key,
    output logic [1:0]  o_removed_level,
    output logic [6:0]  o_removed_payload,
    output logic [15:0] o_head_key,
    output logic [1:0]  o_head_level,
    output logic [4:0]  o_occupancy
);

    localparam int PKB = tlpq_pkg::PORT_KEY_BITS;
    localparam int OCB = tlpq_pkg::OCC_BITS;
    localparam int KW  = (KEY_BITS < PKB) ? KEY_BITS : PKB;
    localparam int CW  = $clog2(DEPTH + 1);

    // cell row wiring
    logic [KW-1:0]   w_key   [DEPTH];
    tlpq_pkg::t_slot w_slot  [DEPTH];
    logic [KW-1:0]   w_n_key [DEPTH];
    tlpq_pkg::t_slot w_n_slot[DEPTH];
    logic [DEPTH-1:0] w_stay;
    logic [DEPTH-1:0] w_hit;
    logic [DEPTH-1:0] w_occ;
    logic [DEPTH-1:0] w_before;
    logic [DEPTH-1:0] w_first;

    tlpq_pkg::t_cell_cmd w_cmd;
    logic [KW-1:0]       w_cmd_key;
    logic [KW-1:0]       w_sel_key;
    tlpq_pkg::t_slot     w_sel_slot;
    logic                w_in_fire;

    // control state
    tlpq_pkg::t_state r_state;
    tlpq_pkg::t_state n_state;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [KW-1:0]    r_ins_key;
    logic [KW-1:0]    n_ins_key;
    tlpq_pkg::t_slot  r_ins_slot;
    tlpq_pkg::t_slot  n_ins_slot;

    // result
    logic             w_produce;
    tlpq_pkg::t_status w_status;
    logic [KW-1:0]    w_rm_key;
    tlpq_pkg::t_slot  w_rm_slot;

    logic             r_out_valid;
    logic [2:0]       r_status;
    logic [15:0]      r_removed_key;
    logic [1:0]       r_removed_level;
    logic [6:0]       r_removed_payload;
    logic [15:0]      r_head_key;
    logic [1:0]       r_head_level;
    logic [4:0]       r_occupancy;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic            w_l_stay;
            logic [KW-1:0]   w_l_key;
            tlpq_pkg::t_slot w_l_slot;
            logic [KW-1:0]   w_r_key;
            tlpq_pkg::t_slot w_r_slot;

            assign w_occ[gi] = (CW'(gi) < r_count);

            if (gi == 0) begin : g_head
                assign w_l_stay     = 1'b1;
                assign w_l_key      = '0;
                assign w_l_slot     = '0;
                assign w_before[gi] = 1'b0;
            end else begin : g_body
                assign w_l_stay     = w_stay[gi-1];
                assign w_l_key      = w_key[gi-1];
                assign w_l_slot     = w_slot[gi-1];
                assign w_before[gi] = |w_hit[gi-1:0];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign w_r_key  = '0;
                assign w_r_slot = '0;
            end else begin : g_mid
                assign w_r_key  = w_key[gi+1];
                assign w_r_slot = w_slot[gi+1];
            end

            tlpq_cell #(
                .KW(KW)
            ) u_cell (
                .i_clk       (i_clk),
                .i_cmd       (w_cmd),
                .i_cmd_key   (w_cmd_key),
                .i_occupied  (w_occ[gi]),
                .i_left_stay (w_l_stay),
                .i_left_hit  (w_before[gi]),
                .i_left_key  (w_l_key),
                .i_left_slot (w_l_slot),
                .i_right_key (w_r_key),
                .i_right_slot(w_r_slot),
                .o_stay      (w_stay[gi]),
                .o_hit       (w_hit[gi]),
                .o_key       (w_key[gi]),
                .o_slot      (w_slot[gi]),
                .o_n_key     (w_n_key[gi]),
                .o_n_slot    (w_n_slot[gi])
            );
        end
    endgenerate

    assign w_first = w_hit & ~w_before;

    // one-hot pick of the first matching slot
    always_comb begin
        w_sel_key  = '0;
        w_sel_slot = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_first[i]) begin
                w_sel_key  = w_sel_key | w_key[i];
                w_sel_slot = w_sel_slot | w_slot[i];
            end
        end
    end

    assign o_in_ready = (r_state == tlpq_pkg::ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_in_fire  = i_in_valid && o_in_ready;

    always_comb begin
        n_state           = r_state;
        n_count           = r_count;
        n_ins_key         = r_ins_key;
        n_ins_slot        = r_ins_slot;
        w_cmd.op          = tlpq_pkg::CELL_HOLD;
        w_cmd.entry.level = i_level;
        w_cmd.entry.payload = i_payload;
        w_cmd_key         = KW'(i_entry_key);
        w_produce         = 1'b0;
        w_status          = tlpq_pkg::STATUS_OK;
        w_rm_key          = '0;
        w_rm_slot         = '0;
        unique case (r_state)
            tlpq_pkg::ST_IDLE: begin
                if (w_in_fire) begin
                    unique case (tlpq_pkg::t_kind'(i_kind))
                        tlpq_pkg::KIND_ADD: begin
                            w_produce = 1'b1;
                            if (i_level == tlpq_pkg::LEVEL_NONE) begin
                                w_status = tlpq_pkg::STATUS_BAD_LEVEL;
                            end else if (r_count == CW'(DEPTH)) begin
                                w_status = tlpq_pkg::STATUS_FULL;
                            end else begin
                                w_cmd.op = tlpq_pkg::CELL_INSERT;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        tlpq_pkg::KIND_POP: begin
                            w_produce = 1'b1;
                            if (r_count == '0) begin
                                w_status = tlpq_pkg::STATUS_EMPTY;
                            end else begin
                                w_cmd.op  = tlpq_pkg::CELL_POP;
                                w_rm_key  = w_key[0];
                                w_rm_slot = w_slot[0];
                                n_count   = r_count - 1'b1;
                            end
                        end
                        tlpq_pkg::KIND_UPDATE: begin
                            if (|w_hit) begin
                                // take the entry out now, put it back next cycle
                                w_cmd.op           = tlpq_pkg::CELL_REMOVE;
                                n_count            = r_count - 1'b1;
                                n_ins_key          = w_sel_key;
                                n_ins_slot.payload = w_sel_slot.payload;
                                n_ins_slot.level   = (i_level == tlpq_pkg::LEVEL_NONE) ?
                                                     w_sel_slot.level : i_level;
                                n_state            = tlpq_pkg::ST_REINSERT;
                            end else begin
                                w_produce = 1'b1;
                                w_status  = tlpq_pkg::STATUS_NOT_FOUND;
                            end
                        end
                        tlpq_pkg::KIND_NOP: begin
                            w_produce = 1'b1;
                        end
                    endcase
                end
            end
            tlpq_pkg::ST_REINSERT: begin
                w_cmd.op    = tlpq_pkg::CELL_INSERT;
                w_cmd.entry = r_ins_slot;
                w_cmd_key   = r_ins_key;
                n_count     = r_count + 1'b1;
                w_produce   = 1'b1;
                n_state     = tlpq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlpq_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ins_key  <= n_ins_key;
        r_ins_slot <= n_ins_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_produce) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // head is taken from the cell row's next contents
    always_ff @(posedge i_clk) begin
        if (w_produce) begin
            r_status          <= w_status;
            r_removed_key     <= PKB'(w_rm_key);
            r_removed_level   <= w_rm_slot.level;
            r_removed_payload <= w_rm_slot.payload;
            r_head_key        <= (n_count != '0) ? PKB'(w_n_key[0]) : '0;
            r_head_level      <= (n_count != '0) ? w_n_slot[0].level : tlpq_pkg::LEVEL_NONE;
            r_occupancy       <= OCB'(n_count);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_removed_key     = r_removed_key;
    assign o_removed_level   = r_removed_level;
    assign o_removed_payload = r_removed_payload;
    assign o_head_key        = r_head_key;
    assign o_head_level      = r_head_level;
    assign o_occupancy       = r_occupancy;

`ifndef ASSERT_OFF
    a_reinsert_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlpq_pkg::ST_REINSERT) |-> !r_out_valid)
        else $error("reinsert pass with result still pending");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && (i_kind == tlpq_pkg::KIND_POP) && (r_count != '0))
        |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not shrink the queue");

    a_update_reinsert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && (i_kind == tlpq_pkg::KIND_UPDATE) && (|w_hit))
        |=> (r_state == tlpq_pkg::ST_REINSERT) && !r_out_valid)
        else $error("found update did not enter reinsert");
`endif

endmodule
